// ===== hdl/ptd_pkg.sv =====
// Package for the trial-division prime table.
// Holds widths, table constants, command and status codes. No dependencies.
`default_nettype none

package ptd_pkg;

  localparam int PRIME_BITS   = 20;
  localparam int COUNT_BITS   = 12;
  localparam int MAX_PRIMES   = 4095;
  localparam int ADDR_BITS    = 12;
  localparam int TABLE_DEPTH  = 1 << ADDR_BITS;
  localparam int DIV_CNT_BITS = $clog2(PRIME_BITS + 1);

  localparam logic CMD_EXTEND = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_CLAMP = 2'd2;

  // Fixed leading entries of the table: 1, 2, 3.
  function automatic logic [PRIME_BITS-1:0] base_entry(input logic [1:0] idx);
    logic [PRIME_BITS-1:0] v;
    v = PRIME_BITS'(1);
    case (idx)
      2'd1:    v = PRIME_BITS'(2);
      2'd2:    v = PRIME_BITS'(3);
      default: v = PRIME_BITS'(1);
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/prime_table_trial_division_top.sv =====
// Prime table built by trial division: command decode, sequencer,
// shared restoring divider and the table memory. Depends on ptd_pkg.
//
//  channel   | ports                                     | handshake
//  ----------+-------------------------------------------+--------------------------
//  command   | cmd, target_count, prime_index            | start && !busy
//  result    | prime_value, prime_count, status          | done, one cycle, no stall
//
// A read passes through the registered memory read and S_RDATA before done;
// one whose index lies beyond the count answers straight from S_IDLE. An
// extend runs one restoring division per stored odd prime tried (S_LOAD,
// S_DIV per quotient bit, S_CHECK), plus S_NEXT per candidate, on the single
// shared subtractor. An extend that asks for no growth answers from S_IDLE.
// Reset (rst, synchronous) sets the count to 2 and the last prime to 3;
// entries 0..2 come from constants, so the memory needs no clearing pass.
// The receiver cannot stall: each word is valid on the result ports only for
// the one cycle that done is high.
`default_nettype none

module prime_table_trial_division_top import ptd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  cmd,
  input  wire logic [COUNT_BITS-1:0] target_count,
  input  wire logic [COUNT_BITS-1:0] prime_index,
  output logic                       done,
  output logic [PRIME_BITS-1:0]      prime_value,
  output logic [COUNT_BITS-1:0]      prime_count,
  output logic [1:0]                 status
);

  localparam logic [2:0] S_IDLE  = 3'd0;  // wait for a command
  localparam logic [2:0] S_RDATA = 3'd1;  // read data back from the table
  localparam logic [2:0] S_NEXT  = 3'd2;  // step to the next odd candidate
  localparam logic [2:0] S_LOAD  = 3'd3;  // pick up a divisor, or pass
  localparam logic [2:0] S_DIV   = 3'd4;  // one quotient bit per cycle
  localparam logic [2:0] S_CHECK = 3'd5;  // judge quotient and remainder

  logic [2:0]              state, state_next;
  logic [COUNT_BITS-1:0]   count, count_next;
  logic [PRIME_BITS-1:0]   last_prime, last_prime_next;
  logic [COUNT_BITS-1:0]   target, target_next;
  logic [COUNT_BITS-1:0]   idx, idx_next;
  logic                    clamp, clamp_next;
  logic [PRIME_BITS-1:0]   cand, cand_next;
  logic [PRIME_BITS-1:0]   divisor, divisor_next;
  logic [COUNT_BITS:0]     lidx, lidx_next;
  logic [PRIME_BITS-1:0]   rem, rem_next;
  logic [PRIME_BITS-1:0]   quo, quo_next;
  logic [DIV_CNT_BITS-1:0] dcnt, dcnt_next;
  logic                    done_next;
  logic [PRIME_BITS-1:0]   prime_value_next;
  logic [1:0]              status_next;

  // Table memory: one write port, one registered read port.
  logic [PRIME_BITS-1:0] mem [TABLE_DEPTH];
  logic [PRIME_BITS-1:0] rdata;
  logic [ADDR_BITS-1:0]  raddr;
  logic [ADDR_BITS-1:0]  waddr;
  logic                  we;

  // Divider datapath and candidate step.
  logic [PRIME_BITS:0]   shifted;
  logic [PRIME_BITS:0]   diff;
  logic                  ge;
  logic [PRIME_BITS:0]   cand_plus;
  logic [COUNT_BITS:0]   count_inc;
  logic                  pass;

  assign busy        = (state != S_IDLE);
  assign prime_count = count;

  assign shifted   = {rem, quo[PRIME_BITS-1]};
  assign ge        = (shifted >= {1'b0, divisor});
  assign diff      = shifted - {1'b0, divisor};
  assign cand_plus = {1'b0, cand} + (PRIME_BITS+1)'(2);
  assign count_inc = {1'b0, count} + (COUNT_BITS+1)'(1);

  // Read address follows the next index, so data is ready in the next state.
  assign raddr = (state == S_IDLE) ? prime_index : lidx_next[ADDR_BITS-1:0];
  assign waddr = count_inc[ADDR_BITS-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= cand;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    state_next       = state;
    count_next       = count;
    last_prime_next  = last_prime;
    target_next      = target;
    idx_next         = idx;
    clamp_next       = clamp;
    cand_next        = cand;
    divisor_next     = divisor;
    lidx_next        = lidx;
    rem_next         = rem;
    quo_next         = quo;
    dcnt_next        = dcnt;
    done_next        = 1'b0;
    prime_value_next = prime_value;
    status_next      = status;
    we               = 1'b0;
    pass             = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          idx_next  = prime_index;
          cand_next = last_prime;
          if (cmd == CMD_READ) begin
            if (prime_index > count) begin
              // Index beyond count: answer at once.
              done_next        = 1'b1;
              prime_value_next = '0;
              status_next      = ST_RANGE;
            end else begin
              state_next = S_RDATA;
            end
          end else begin
            if (32'(target_count) > MAX_PRIMES) begin
              target_next = COUNT_BITS'(MAX_PRIMES);
              clamp_next  = 1'b1;
            end else begin
              target_next = target_count;
              clamp_next  = 1'b0;
            end
            if (target_next <= count) begin
              done_next        = 1'b1;
              prime_value_next = '0;
              status_next      = clamp_next ? ST_CLAMP : ST_OK;
            end else begin
              state_next = S_NEXT;
            end
          end
        end
      end

      S_RDATA: begin
        done_next        = 1'b1;
        prime_value_next = (idx <= COUNT_BITS'(2)) ? base_entry(idx[1:0]) : rdata;
        status_next      = ST_OK;
        state_next       = S_IDLE;
      end

      S_NEXT: begin
        if (cand_plus[PRIME_BITS]) begin
          // Next candidate does not fit: stop early.
          done_next        = 1'b1;
          prime_value_next = '0;
          status_next      = ST_CLAMP;
          state_next       = S_IDLE;
        end else begin
          cand_next  = cand_plus[PRIME_BITS-1:0];
          lidx_next  = (COUNT_BITS+1)'(2);
          state_next = S_LOAD;
        end
      end

      S_LOAD: begin
        if (lidx > {1'b0, count}) begin
          pass = 1'b1;
        end else begin
          divisor_next = (lidx <= (COUNT_BITS+1)'(2)) ? base_entry(lidx[1:0]) : rdata;
          rem_next     = '0;
          quo_next     = cand;
          dcnt_next    = DIV_CNT_BITS'(PRIME_BITS);
          state_next   = S_DIV;
        end
      end

      S_DIV: begin
        rem_next  = ge ? diff[PRIME_BITS-1:0] : shifted[PRIME_BITS-1:0];
        quo_next  = {quo[PRIME_BITS-2:0], ge};
        dcnt_next = dcnt - DIV_CNT_BITS'(1);
        if (dcnt == DIV_CNT_BITS'(1)) begin
          state_next = S_CHECK;
        end
      end

      S_CHECK: begin
        if (divisor > quo) begin
          // Divisor squared exceeds the candidate: no factor left to try.
          pass = 1'b1;
        end else if (rem == '0) begin
          state_next = S_NEXT;
        end else begin
          lidx_next  = lidx + (COUNT_BITS+1)'(1);
          state_next = S_LOAD;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Append a candidate that survived trial division.
    if (pass) begin
      we              = 1'b1;
      count_next      = count_inc[COUNT_BITS-1:0];
      last_prime_next = cand;
      if (count_inc >= {1'b0, target}) begin
        done_next        = 1'b1;
        prime_value_next = '0;
        status_next      = clamp ? ST_CLAMP : ST_OK;
        state_next       = S_IDLE;
      end else begin
        state_next = S_NEXT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= COUNT_BITS'(2);
      last_prime <= PRIME_BITS'(3);
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      last_prime <= last_prime_next;
      done       <= done_next;
    end
  end

  // Payload and datapath registers: no reset needed.
  always_ff @(posedge clk) begin
    target      <= target_next;
    idx         <= idx_next;
    clamp       <= clamp_next;
    cand        <= cand_next;
    divisor     <= divisor_next;
    lidx        <= lidx_next;
    rem         <= rem_next;
    quo         <= quo_next;
    dcnt        <= dcnt_next;
    prime_value <= prime_value_next;
    status      <= status_next;
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the trial-division prime table.
// Drives extend and read words, predicts every result word with its own table copy.
// Depends on ptd_pkg and prime_table_trial_division_top.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ptd_pkg::*;

  // Random words in each of the two random phases, and the count at which
  // the first phase stops growing the table so that it stays cheap.
  localparam int RAND_SMALL  = 300;
  localparam int RAND_FULL   = 100;
  localparam int SMALL_CAP   = 600;
  localparam int DIR_ROWS    = 24;
  localparam int DRAIN_WAIT  = 8;

  typedef struct packed {
    logic [PRIME_BITS-1:0] value;
    logic [COUNT_BITS-1:0] count;
    logic [1:0]            status;
  } prime_word_t;

  // One directed stimulus row; a set 'typed' bit means the listed result
  // is checked instead of the predicted one.
  typedef struct packed {
    logic                  cmd;
    logic [COUNT_BITS-1:0] tgt;
    logic [COUNT_BITS-1:0] idx;
    logic                  typed;
    logic [PRIME_BITS-1:0] value;
    logic [COUNT_BITS-1:0] count;
    logic [1:0]            status;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  cmd = CMD_EXTEND;
  logic [COUNT_BITS-1:0] target_count = '0;
  logic [COUNT_BITS-1:0] prime_index = '0;
  logic                  busy;
  logic                  done;
  logic [PRIME_BITS-1:0] prime_value;
  logic [COUNT_BITS-1:0] prime_count;
  logic [1:0]            status;

  prime_table_trial_division_top uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .target_count (target_count),
    .prime_index  (prime_index),
    .done         (done),
    .prime_value  (prime_value),
    .prime_count  (prime_count),
    .status       (status)
  );

  always #5 clk = ~clk;

  // Predictor state: our own copy of the prime table and its fill count.
  logic [PRIME_BITS-1:0] known_primes [0:MAX_PRIMES];
  int unsigned           known_count;

  prime_word_t pending_words [$];
  int          mismatch_count = 0;
  int          calm_left = 0;
  dir_row_t    directed_rows [DIR_ROWS];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  task automatic clear_known_table();
    for (int n = 0; n <= MAX_PRIMES; n++) known_primes[n] = '0;
    known_primes[0] = PRIME_BITS'(1);
    known_primes[1] = PRIME_BITS'(2);
    known_primes[2] = PRIME_BITS'(3);
    known_count = 2;
  endtask

  // Try every stored odd prime p with p*p <= cand; stop at the first divisor.
  function automatic bit survives_trial(input longint unsigned cand);
    longint unsigned p;
    for (int unsigned l = 2; l <= known_count; l++) begin
      p = known_primes[l];
      if (p == 0 || p > cand / p) return 1'b1;
      if (cand % p == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Append primes until the goal is met; a set return flags a candidate
  // that no longer fits in PRIME_BITS.
  function automatic bit grow_table(input int unsigned goal);
    longint unsigned cand;
    cand = known_primes[known_count];
    while (known_count < goal) begin
      cand += 2;
      if (cand > ((64'd1 << PRIME_BITS) - 1)) return 1'b1;
      if (survives_trial(cand)) begin
        known_count++;
        known_primes[known_count] = PRIME_BITS'(cand);
      end
    end
    return 1'b0;
  endfunction

  function automatic prime_word_t predict_word(input logic c, input logic [COUNT_BITS-1:0] t,
                                               input logic [COUNT_BITS-1:0] i);
    prime_word_t w;
    int unsigned goal;
    w.value  = '0;
    w.status = ST_OK;
    if (c == CMD_EXTEND) begin
      goal = t;
      if (goal > MAX_PRIMES) begin
        goal     = MAX_PRIMES;
        w.status = ST_CLAMP;
      end
      if (grow_table(goal)) w.status = ST_CLAMP;
    end else if (i > known_count || i > MAX_PRIMES) begin
      w.status = ST_RANGE;
    end else begin
      w.value = known_primes[i];
    end
    w.count = COUNT_BITS'(known_count);
    return w;
  endfunction

  // Issue one command word: idle for a random gap (or none inside a calm
  // stretch), hold start until the block takes the word, then predict.
  // Start stays high after acceptance; the next call lowers it only when
  // it idles, so start never sees two assignments in one step.
  task automatic issue_word(input logic c, input logic [COUNT_BITS-1:0] t,
                            input logic [COUNT_BITS-1:0] i, input bit typed,
                            input prime_word_t typed_word);
    int          gap;
    prime_word_t w;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(10, 30);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    cmd          <= c;
    target_count <= t;
    prime_index  <= i;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Accepted at this edge: the predictor always advances, even when the
    // row carries its own typed result.
    w = predict_word(c, t, i);
    pending_words.insert(pending_words.size(), typed ? typed_word : w);
  endtask

  // Check each result word against the oldest expectation. Done marks the
  // one cycle the word is valid; the edge that ends it accepts it.
  always @(posedge clk) begin : check_words
    prime_word_t want;
    if (!rst && done) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word, prime_value", prime_value, 0);
      end else begin
        want = pending_words.pop_front();
        if (prime_value !== want.value) report_mismatch("prime_value", prime_value, want.value);
        if (prime_count !== want.count) report_mismatch("prime_count", prime_count, want.count);
        if (status !== want.status) report_mismatch("status", status, want.status);
      end
    end
  end

  initial begin : stimulus
    prime_word_t           typed_word;
    logic                  c;
    logic [COUNT_BITS-1:0] t;
    logic [COUNT_BITS-1:0] i;
    int unsigned           roll;

    // Directed rows: reset contents, reads past the count, no-op extends,
    // small growth steps, and extremes of the unused field.
    directed_rows = '{
      '{CMD_READ,   12'd4095, 12'd0,    1'b1, 20'd1,  12'd2,  ST_OK},
      '{CMD_READ,   12'd0,    12'd1,    1'b1, 20'd2,  12'd2,  ST_OK},
      '{CMD_READ,   12'd0,    12'd2,    1'b1, 20'd3,  12'd2,  ST_OK},
      '{CMD_READ,   12'd0,    12'd3,    1'b1, 20'd0,  12'd2,  ST_RANGE},
      '{CMD_READ,   12'd4095, 12'd4095, 1'b1, 20'd0,  12'd2,  ST_RANGE},
      '{CMD_EXTEND, 12'd0,    12'd4095, 1'b1, 20'd0,  12'd2,  ST_OK},
      '{CMD_EXTEND, 12'd2,    12'd0,    1'b1, 20'd0,  12'd2,  ST_OK},
      '{CMD_EXTEND, 12'd3,    12'd0,    1'b1, 20'd0,  12'd3,  ST_OK},
      '{CMD_READ,   12'd0,    12'd3,    1'b1, 20'd5,  12'd3,  ST_OK},
      '{CMD_READ,   12'd0,    12'd4,    1'b1, 20'd0,  12'd3,  ST_RANGE},
      '{CMD_EXTEND, 12'd10,   12'd0,    1'b1, 20'd0,  12'd10, ST_OK},
      '{CMD_READ,   12'd0,    12'd10,   1'b1, 20'd29, 12'd10, ST_OK},
      '{CMD_READ,   12'd0,    12'd11,   1'b1, 20'd0,  12'd10, ST_RANGE},
      '{CMD_EXTEND, 12'd5,    12'd0,    1'b1, 20'd0,  12'd10, ST_OK},
      '{CMD_EXTEND, 12'd25,   12'd0,    1'b1, 20'd0,  12'd25, ST_OK},
      '{CMD_READ,   12'd0,    12'd25,   1'b1, 20'd97, 12'd25, ST_OK},
      '{CMD_READ,   12'd0,    12'd9,    1'b1, 20'd23, 12'd25, ST_OK},
      '{CMD_EXTEND, 12'd26,   12'd2730, 1'b0, 20'd0,  12'd0,  ST_OK},
      '{CMD_READ,   12'd1365, 12'd26,   1'b0, 20'd0,  12'd0,  ST_OK},
      '{CMD_EXTEND, 12'd40,   12'd0,    1'b0, 20'd0,  12'd0,  ST_OK},
      '{CMD_READ,   12'd0,    12'd40,   1'b0, 20'd0,  12'd0,  ST_OK},
      '{CMD_READ,   12'd0,    12'd0,    1'b1, 20'd1,  12'd40, ST_OK},
      '{CMD_EXTEND, 12'd41,   12'd0,    1'b0, 20'd0,  12'd0,  ST_OK},
      '{CMD_READ,   12'd0,    12'd41,   1'b0, 20'd0,  12'd0,  ST_OK}
    };

    clear_known_table();

    // Hold reset once at the start, then release it.
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table.
    for (int r = 0; r < DIR_ROWS; r++) begin
      typed_word.value  = directed_rows[r].value;
      typed_word.count  = directed_rows[r].count;
      typed_word.status = directed_rows[r].status;
      issue_word(directed_rows[r].cmd, directed_rows[r].tgt, directed_rows[r].idx,
                 directed_rows[r].typed, typed_word);
    end

    // Random phase on a small table: mostly reads inside the table plus
    // short growth steps, with reads past the end and extends that ask for
    // no growth mixed in. Stop growing at SMALL_CAP to keep the divider work
    // modest until the one full build below.
    for (int n = 0; n < RAND_SMALL; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        c = CMD_EXTEND;
        i = COUNT_BITS'($urandom);
        if (known_count < SMALL_CAP && $urandom_range(0, 3) != 0)
          t = COUNT_BITS'(known_count + $urandom_range(0, 24));
        else
          t = COUNT_BITS'($urandom_range(0, known_count));
      end else begin
        c = CMD_READ;
        t = COUNT_BITS'($urandom);
        roll = $urandom_range(0, 9);
        if (roll < 8)       i = COUNT_BITS'($urandom_range(0, known_count));
        else if (roll == 8) i = COUNT_BITS'(known_count + 1);
        else                i = COUNT_BITS'($urandom);
      end
      issue_word(c, t, i, 1'b0, typed_word);
    end

    // Fill the table to capacity once, then read its last entry. The clamp
    // status cannot arise: a 12-bit target never exceeds capacity and the
    // last prime fits well inside PRIME_BITS.
    typed_word.value  = '0;
    typed_word.count  = COUNT_BITS'(MAX_PRIMES);
    typed_word.status = ST_OK;
    issue_word(CMD_EXTEND, COUNT_BITS'(MAX_PRIMES), COUNT_BITS'($urandom), 1'b1, typed_word);
    issue_word(CMD_READ, COUNT_BITS'($urandom), COUNT_BITS'(MAX_PRIMES), 1'b0, typed_word);

    // Random phase on the full table: full-range targets and indexes.
    for (int n = 0; n < RAND_FULL; n++) begin
      c = ($urandom_range(0, 1) == 0) ? CMD_EXTEND : CMD_READ;
      issue_word(c, COUNT_BITS'($urandom), COUNT_BITS'($urandom), 1'b0, typed_word);
    end

    // Drop start, drain the outstanding words, then keep waiting so that any
    // stray word can still show up.
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Guard against a hang: end the run with an error if the stimulus does not
  // finish first, leaving ample time for the full table build.
  initial begin : watchdog
    #1000000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

`default_nettype wire
